[design/assert_macros.svh]
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is asserted.
`define BCTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bcts assertion failed");

// Next-cycle implication, off while reset is asserted.
`define BCTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bcts assertion failed");

`endif

[design/bcts_pkg.sv]
// Shared constants, types and helpers of the binary cosine top-k search unit.
// No dependencies.
package bcts_pkg;

  localparam int TOP_ENTRIES = 16;
  localparam int INDEX_BITS  = 24;
  localparam int DESC_BITS   = 256;
  localparam int WORD_BITS   = 64;
  localparam int CNT_W       = $clog2(DESC_BITS + 1);   // popcount width
  localparam int PROD_W      = 2 * CNT_W - 1;           // pa*pb <= 2^16
  localparam int SCORE_W     = 17;
  localparam int TGT_W       = PROD_W + 32;             // pand^2 << 32
  localparam int SUM_W       = TGT_W + 3;               // trial square sum
  localparam int CP_W        = SCORE_W + PROD_W;        // c * P
  localparam int RC_W        = 5;
  localparam int KW          = $clog2(TOP_ENTRIES + 1);
  localparam int TW          = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;
  localparam int BIT_W       = 5;
  localparam int CFG_AW      = 3;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_QUERY0 = 3'd0,
    CFG_QUERY1 = 3'd1,
    CFG_QUERY2 = 3'd2,
    CFG_QUERY3 = 3'd3,
    CFG_COUNT  = 3'd4
  } cfg_idx_e;

  // One scored job handed from front to back
  typedef struct packed {
    logic [PROD_W-1:0]     prod;
    logic [TGT_W-1:0]      target;
    logic [INDEX_BITS-1:0] pos;
    logic                  last;
  } job_t;

  // Clamp result_count to 1..TOP_ENTRIES
  function automatic logic [KW-1:0] limit_count(input logic [RC_W-1:0] rc);
    logic [KW-1:0] k;
    if (rc == '0) begin
      k = KW'(1);
    end else if (32'(rc) > 32'(TOP_ENTRIES)) begin
      k = KW'(TOP_ENTRIES);
    end else begin
      k = KW'(rc);
    end
    return k;
  endfunction

endpackage

[design/bcts_front.sv]
// Front end: accepts descriptors, counts bits against the query, tags index.
// Depends on bcts_pkg.
module bcts_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [bcts_pkg::DESC_BITS-1:0]       query_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bcts_pkg::DESC_BITS-1:0]       entry_i,
  input  logic                                 last_i,
  output logic                                 job_valid_o,
  input  logic                                 job_ready_i,
  output bcts_pkg::job_t                       job_o
);

  logic                              valid_q;
  logic [bcts_pkg::CNT_W-1:0]        pa_q, pb_q, pand_q;
  logic [bcts_pkg::INDEX_BITS-1:0]   pos_q, ctr_q;
  logic                              last_q;
  logic                              accept;
  logic [2*bcts_pkg::CNT_W-1:0]      prod_full, sq_full;

  assign in_ready_o = !valid_q || job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Count bits and tag the arrival index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ctr_q   <= '0;
    end else begin
      if (accept) begin
        valid_q <= 1'b1;
        if (last_i) begin
          ctr_q <= '0;
        end else if (ctr_q != '1) begin
          ctr_q <= ctr_q + 1'b1;
        end
      end else if (job_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pa_q   <= bcts_pkg::CNT_W'($countones(query_i));
      pb_q   <= bcts_pkg::CNT_W'($countones(entry_i));
      pand_q <= bcts_pkg::CNT_W'($countones(query_i & entry_i));
      pos_q  <= ctr_q;
      last_q <= last_i;
    end
  end

  // Form the product and the compare target
  assign prod_full = pa_q * pb_q;
  assign sq_full   = pand_q * pand_q;

  assign job_valid_o   = valid_q;
  assign job_o.prod    = prod_full[bcts_pkg::PROD_W-1:0];
  assign job_o.target  = {sq_full[bcts_pkg::PROD_W-1:0], 32'd0};
  assign job_o.pos     = pos_q;
  assign job_o.last    = last_q;

endmodule

[design/bcts_fifo.sv]
// Two-word queue between front and back.
// Depends on bcts_pkg.
module bcts_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  bcts_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output bcts_pkg::job_t pop_data_o
);

  bcts_pkg::job_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

[design/bcts_back.sv]
// Back end: bit-serial square root search, sorted insert, result emission.
// Depends on bcts_pkg.
module bcts_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [bcts_pkg::RC_W-1:0]            result_count_i,
  input  logic                                 job_valid_i,
  output logic                                 job_ready_o,
  input  bcts_pkg::job_t                       job_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bcts_pkg::INDEX_BITS-1:0]      match_index_o,
  output logic [bcts_pkg::SCORE_W-1:0]         match_score_o,
  output logic                                 last_match_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_INSERT,
    ST_EMIT
  } state_e;

  localparam int TOP = bcts_pkg::TOP_ENTRIES;
  localparam int KW  = bcts_pkg::KW;
  localparam int TW  = bcts_pkg::TW;

  state_e                            state_q;
  bcts_pkg::job_t                    job_q;
  logic [bcts_pkg::BIT_W-1:0]        bit_q;
  logic [bcts_pkg::SCORE_W-1:0]      c_q;
  logic [bcts_pkg::CP_W-1:0]         cp_q;
  logic [bcts_pkg::SUM_W-1:0]        c2p_q;
  logic [bcts_pkg::SCORE_W-1:0]      score_q [TOP];
  logic [bcts_pkg::INDEX_BITS-1:0]   pos_q   [TOP];
  logic [KW-1:0]                     kept_q;
  logic [TW-1:0]                     ei_q;
  logic                              out_valid_q;
  logic [bcts_pkg::INDEX_BITS-1:0]   out_index_q;
  logic [bcts_pkg::SCORE_W-1:0]      out_score_q;
  logic                              out_last_q;

  logic [bcts_pkg::SUM_W-1:0]        trial;
  logic                              fits;
  logic [bcts_pkg::SCORE_W-1:0]      sc;
  logic [KW-1:0]                     k, km1, nn, n_emit, kept_d;
  logic                              full, reject;
  logic [TOP-1:0]                    keep;
  logic [bcts_pkg::SCORE_W-1:0]      score_d [TOP];
  logic [bcts_pkg::INDEX_BITS-1:0]   pos_d   [TOP];
  logic                              slot_free, emit_last;

  assign job_ready_o = (state_q == ST_IDLE);

  // Trial square times product, built from running sums
  assign trial = c2p_q
               + (bcts_pkg::SUM_W'(cp_q) << (bit_q + 1'b1))
               + (bcts_pkg::SUM_W'(job_q.prod) << {bit_q, 1'b0});
  assign fits  = (trial <= bcts_pkg::SUM_W'(job_q.target));

  // Sorted insert into the kept table
  assign sc   = (job_q.prod == '0) ? '0 : c_q;
  assign k    = bcts_pkg::limit_count(result_count_i);
  assign km1  = k - 1'b1;
  assign full = (kept_q >= k);
  assign reject = full && (sc <= score_q[km1[TW-1:0]]);
  assign nn   = full ? km1 : kept_q;
  assign kept_d = reject ? k : nn + 1'b1;

  always_comb begin
    for (int i = 0; i < TOP; i++) begin
      keep[i] = (KW'(i) < nn) && (score_q[i] >= sc);
    end
    score_d[0] = score_q[0];
    pos_d[0]   = pos_q[0];
    if (!keep[0]) begin
      score_d[0] = sc;
      pos_d[0]   = job_q.pos;
    end
    for (int i = 1; i < TOP; i++) begin
      score_d[i] = score_q[i];
      pos_d[i]   = pos_q[i];
      if (!(KW'(i) > nn) && !keep[i]) begin
        if (keep[i-1]) begin
          score_d[i] = sc;
          pos_d[i]   = job_q.pos;
        end else begin
          score_d[i] = score_q[i-1];
          pos_d[i]   = pos_q[i-1];
        end
      end
    end
  end

  // Emission bookkeeping
  assign n_emit    = (kept_q < k) ? kept_q : k;
  assign emit_last = ((KW'(ei_q) + 1'b1) == n_emit);
  assign slot_free = !out_valid_q || out_ready_i;

  // Sequencer with registered output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
      ei_q        <= '0;
    end else begin
      if (state_q == ST_EMIT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            bit_q   <= bcts_pkg::BIT_W'(bcts_pkg::SCORE_W - 1);
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (bit_q == '0) state_q <= ST_INSERT;
          else             bit_q   <= bit_q - 1'b1;
        end
        ST_INSERT: begin
          kept_q <= kept_d;
          ei_q   <= '0;
          state_q <= job_q.last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (emit_last) begin
              kept_q  <= '0;
              state_q <= ST_IDLE;
            end else begin
              ei_q <= ei_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i) begin
      job_q <= job_i;
      c_q   <= '0;
      cp_q  <= '0;
      c2p_q <= '0;
    end
    if (state_q == ST_ROOT && fits) begin
      c_q   <= c_q | (bcts_pkg::SCORE_W'(1) << bit_q);
      c2p_q <= trial;
      cp_q  <= cp_q + (bcts_pkg::CP_W'(job_q.prod) << bit_q);
    end
    if (state_q == ST_INSERT && !reject) begin
      for (int i = 0; i < TOP; i++) begin
        score_q[i] <= score_d[i];
        pos_q[i]   <= pos_d[i];
      end
    end
    if (state_q == ST_EMIT && slot_free) begin
      out_index_q <= pos_q[ei_q];
      out_score_q <= score_q[ei_q];
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_index_o = out_index_q;
  assign match_score_o = out_score_q;
  assign last_match_o  = out_last_q;

endmodule

[design/binary_cosine_top_k_search_unit.sv]
// Top level of the binary cosine top-k search unit: config registers, front,
// queue and back. Depends on bcts_pkg, bcts_front, bcts_fifo, bcts_back.
//
//  channel   direction  handshake             payload
//  cfg       in         cfg_we_i              cfg_addr_i, cfg_wdata_i
//  entry     in         in_valid_i/in_ready_o entry_word0..3_i, last_entry_i
//  match     out        out_valid_o/out_ready_i match_index_o, match_score_o,
//                                             last_match_o
//
// Each entry passes through the back end as a load, the bit-serial square
// root (one score bit per cycle) and the sorted insert.
// A last entry then emits the reported matches, best first, via the output slot.
// The front and a two-word queue accept entries while the back is busy.
// Reset clears control state and the kept table count; no clearing pass.
module binary_cosine_top_k_search_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bcts_pkg::CFG_AW-1:0]          cfg_addr_i,
  input  logic [bcts_pkg::WORD_BITS-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bcts_pkg::WORD_BITS-1:0]       entry_word0_i,
  input  logic [bcts_pkg::WORD_BITS-1:0]       entry_word1_i,
  input  logic [bcts_pkg::WORD_BITS-1:0]       entry_word2_i,
  input  logic [bcts_pkg::WORD_BITS-1:0]       entry_word3_i,
  input  logic                                 last_entry_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bcts_pkg::INDEX_BITS-1:0]      match_index_o,
  output logic [bcts_pkg::SCORE_W-1:0]         match_score_o,
  output logic                                 last_match_o
);

  logic [bcts_pkg::WORD_BITS-1:0] query_q [4];
  logic [bcts_pkg::RC_W-1:0]      rc_q;
  logic                           job_valid, job_ready, q_valid, q_ready;
  bcts_pkg::job_t                 job, q_job;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) query_q[i] <= '0;
      rc_q <= bcts_pkg::RC_W'(16);
    end else if (cfg_we_i) begin
      case (bcts_pkg::cfg_idx_e'(cfg_addr_i))
        bcts_pkg::CFG_QUERY0: query_q[0] <= cfg_wdata_i;
        bcts_pkg::CFG_QUERY1: query_q[1] <= cfg_wdata_i;
        bcts_pkg::CFG_QUERY2: query_q[2] <= cfg_wdata_i;
        bcts_pkg::CFG_QUERY3: query_q[3] <= cfg_wdata_i;
        bcts_pkg::CFG_COUNT:  rc_q <= cfg_wdata_i[bcts_pkg::RC_W-1:0];
        default: ;
      endcase
    end
  end

  bcts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .query_i     ({query_q[3], query_q[2], query_q[1], query_q[0]}),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .entry_i     ({entry_word3_i, entry_word2_i, entry_word1_i, entry_word0_i}),
    .last_i      (last_entry_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  bcts_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  bcts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .result_count_i (rc_q),
    .job_valid_i    (q_valid),
    .job_ready_o    (q_ready),
    .job_i          (q_job),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .match_index_o  (match_index_o),
    .match_score_o  (match_score_o),
    .last_match_o   (last_match_o)
  );

endmodule

[design/bcts_checker.sv]
// Port-level checker for the search unit, bound to the top level.
// Depends on bcts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bcts_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               last_entry_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [bcts_pkg::INDEX_BITS-1:0]    match_index_o,
  input logic [bcts_pkg::SCORE_W-1:0]       match_score_o,
  input logic                               last_match_o
);

  logic [7:0] pend_q;
  logic       in_last, out_last;

  assign in_last  = in_valid_i && in_ready_o && last_entry_i;
  assign out_last = out_valid_o && out_ready_i && last_match_o;

  // Track searches closed at the input but not yet fully reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_last && !out_last) begin
      pend_q <= pend_q + 8'd1;
    end else if (out_last && !in_last) begin
      pend_q <= pend_q - 8'd1;
    end
  end

  `BCTS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(match_index_o) && $stable(match_score_o) && $stable(last_match_o))
  `BCTS_ASSERT_IMP(a_score_range, clk_i, rst_ni, out_valid_o, match_score_o <= 17'd65536)
  `BCTS_ASSERT_IMP(a_no_early_match, clk_i, rst_ni, out_valid_o, pend_q != 8'd0)

endmodule

bind binary_cosine_top_k_search_unit bcts_checker u_bcts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .last_entry_i  (last_entry_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .match_index_o (match_index_o),
  .match_score_o (match_score_o),
  .last_match_o  (last_match_o)
);

[dv/tb_binary_cosine_top_k_search_unit.sv]
// Self-checking testbench of the binary cosine top-k search unit.
// Needs bcts_pkg and binary_cosine_top_k_search_unit; scores and ranks in its own model.
`timescale 1ns / 1ps

class match_scoreboard;
  bit [63:0]  query [4];
  bit [4:0]   keep_reg;
  bit [16:0]  kept_score [16];
  bit [23:0]  kept_pos [16];
  int         kept_n;
  bit [23:0]  arrival;
  bit [23:0]  want_index [$];
  bit [16:0]  want_score [$];
  bit         want_last [$];
  int         errors;

  function new();
    keep_reg = 5'd16;
    kept_n = 0;
    arrival = '0;
    errors = 0;
  endfunction

  function int keep_limit();
    int k;
    k = keep_reg;
    if (k == 0) k = 1;
    if (k > bcts_pkg::TOP_ENTRIES) k = bcts_pkg::TOP_ENTRIES;
    return k;
  endfunction

  function bit [16:0] cosine(bit [255:0] e);
    bit [255:0] q;
    longint unsigned pa, pb, pand, target, c, t;
    q = {query[3], query[2], query[1], query[0]};
    pa = $countones(q);
    pb = $countones(e);
    pand = $countones(q & e);
    if (pa == 0 || pb == 0) return '0;
    target = (pand * pand) << 32;
    c = 0;
    for (int b = 16; b >= 0; b--) begin
      t = c | (64'd1 << b);
      if (t * t * pa * pb <= target) c = t;
    end
    return c[16:0];
  endfunction

  // Note one accepted entry; queue the ranked matches when it closes a search
  function void note_entry(bit [255:0] e, bit last);
    bit [16:0] s;
    int k, n, at;
    s = cosine(e);
    k = keep_limit();
    n = kept_n;
    if (n >= k) begin
      n = k - 1;
      if (s <= kept_score[k-1]) begin
        n = -1;
        kept_n = k;
      end
    end
    if (n >= 0) begin
      at = n;
      while (at > 0 && kept_score[at-1] < s) at--;
      for (int i = n; i > at; i--) begin
        kept_score[i] = kept_score[i-1];
        kept_pos[i] = kept_pos[i-1];
      end
      kept_score[at] = s;
      kept_pos[at] = arrival;
      kept_n = n + 1;
    end
    if (arrival != 24'hFFFFFF) arrival++;
    if (last) begin
      n = (kept_n < k) ? kept_n : k;
      for (int i = 0; i < n; i++) begin
        want_index.push_back(kept_pos[i]);
        want_score.push_back(kept_score[i]);
        want_last.push_back(i == n - 1);
      end
      kept_n = 0;
      arrival = '0;
      for (int i = 0; i < 16; i++) begin
        kept_score[i] = '0;
        kept_pos[i] = '0;
      end
    end
  endfunction

  task mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Compare one accepted match against the oldest expectation
  task check_match(bit [23:0] idx, bit [16:0] sc, bit lst);
    if (want_index.size() == 0) begin
      mismatch($sformatf("unexpected match idx=%0d score=%0d", idx, sc));
      return;
    end
    if (idx != want_index[0])
      mismatch($sformatf("index %0d, want %0d", idx, want_index[0]));
    if (sc != want_score[0])
      mismatch($sformatf("score %0d, want %0d", sc, want_score[0]));
    if (lst != want_last[0])
      mismatch($sformatf("last_match %0b, want %0b", lst, want_last[0]));
    void'(want_index.pop_front());
    void'(want_score.pop_front());
    void'(want_last.pop_front());
  endtask
endclass

module tb_binary_cosine_top_k_search_unit;

  localparam int LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bcts_pkg::CFG_AW-1:0] cfg_addr_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [63:0] entry_word0_i = '0, entry_word1_i = '0, entry_word2_i = '0, entry_word3_i = '0;
  logic last_entry_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [bcts_pkg::INDEX_BITS-1:0] match_index_o;
  logic [bcts_pkg::SCORE_W-1:0] match_score_o;
  logic last_match_o;

  match_scoreboard sb = new();
  int send_idle = 0;   // percent
  int recv_stall = 0;  // percent
  int hold_cycles = 0;
  int cycle = 0;

  binary_cosine_top_k_search_unit i_dut (.*);

  always #6 clk_i = ~clk_i;

  // Abort at the cycle limit
  always @(posedge clk_i) begin
    cycle++;
    if (cycle > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check each accepted match word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_match(match_index_o, match_score_o, last_match_o);
  end

  // Drive ready: long hold-offs first, then random stalls
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(bcts_pkg::cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bcts_pkg::CFG_COUNT) sb.keep_reg = val[4:0];
    else sb.query[idx] = val;
  endtask

  // Offer one entry and hold it until accepted; valid stays high after
  task automatic send_entry(logic [255:0] e, logic last);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {entry_word3_i, entry_word2_i, entry_word1_i, entry_word0_i} <= e;
    last_entry_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_entry(e, last);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every expected match and let the block go idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.want_index.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [255:0] rand_vec(int mode);
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    case (mode)
      0: v = '0;
      1: v = '1;
      2: v = {sb.query[3], sb.query[2], sb.query[1], sb.query[0]};
      3: v = v & {sb.query[3], sb.query[2], sb.query[1], sb.query[0]};
      4: v = v & {8{$urandom}} & {8{$urandom}};
      default: ;
    endcase
    return v;
  endfunction

  task automatic rand_search(int len);
    for (int i = 0; i < len; i++)
      send_entry(rand_vec($urandom_range(7)), i == len - 1);
  endtask

  task automatic rand_query();
    for (int w = 0; w < 4; w++) begin
      case ($urandom_range(5))
        0: write_reg(bcts_pkg::cfg_idx_e'(w), '0);
        1: write_reg(bcts_pkg::cfg_idx_e'(w), '1);
        default: write_reg(bcts_pkg::cfg_idx_e'(w), {$urandom, $urandom});
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero query, full query, ties, full-table replacement
    send_entry('0, 1'b1);
    drain();
    write_reg(bcts_pkg::CFG_QUERY0, '1);
    write_reg(bcts_pkg::CFG_QUERY1, '1);
    write_reg(bcts_pkg::CFG_QUERY2, '1);
    write_reg(bcts_pkg::CFG_QUERY3, '1);
    write_reg(bcts_pkg::CFG_COUNT, 64'd2);
    send_entry('0, 1'b0);
    send_entry({128'h0, {128{1'b1}}}, 1'b0);
    send_entry({128'h0, {128{1'b1}}}, 1'b0);
    send_entry('1, 1'b0);
    send_entry({255'h0, 1'b1}, 1'b1);
    drain();
    write_reg(bcts_pkg::CFG_QUERY0, 64'hAAAA_AAAA_5555_5555);
    write_reg(bcts_pkg::CFG_COUNT, 64'd0);
    send_entry({4{64'hAAAA_AAAA_5555_5555}}, 1'b0);
    send_entry({4{64'h5555_5555_AAAA_AAAA}}, 1'b1);
    drain();
    write_reg(bcts_pkg::CFG_COUNT, 64'd31);
    for (int i = 0; i < 20; i++) send_entry(rand_vec(i % 5 + 1), i == 19);
    drain();
    // Lower the count mid-search, once the block has gone idle
    write_reg(bcts_pkg::CFG_COUNT, 64'd16);
    for (int i = 0; i < 8; i++) send_entry(rand_vec(7), 1'b0);
    drain();
    write_reg(bcts_pkg::CFG_COUNT, 64'd3);
    send_entry(rand_vec(3), 1'b1);
    drain();

    // Random searches across idle phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 51 : 24) : 0;
      recv_stall = (ph == 2) ? 51 : ((ph == 3) ? 24 : 0);
      for (int s = 0; s < 5; s++) begin
        rand_query();
        write_reg(bcts_pkg::CFG_COUNT, 64'($urandom_range(20)));
        // Hold the receiver off while a second search piles up behind the first
        if (ph == 0 && s == 0) begin
          hold_cycles = 1500;
          rand_search(10);
        end
        rand_search($urandom_range(1, 28));
        drain();
      end
    end

    // Finish
    send_idle = 0;
    recv_stall = 0;
    if (sb.errors == 0 && sb.want_index.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
